FILE: rtl/matrix_chain_order_defines.svh
// ----------------------------------------------------------------------------
// Matrix chain order assertion macros
// Shared concurrent assertion forms for the matrix chain order block.
// ----------------------------------------------------------------------------
`ifndef MATRIX_CHAIN_ORDER_DEFINES_SVH
`define MATRIX_CHAIN_ORDER_DEFINES_SVH

// Property checked at every clock edge outside reset
`define MCO_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define MCO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mco_pkg.sv
// ----------------------------------------------------------------------------
// Matrix chain order package
// Field widths, constants and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mco_pkg;

   localparam int DIM_W   = 16;   // dimension field width
   localparam int IDX_W   = 4;    // matrix index field width
   localparam int SPLIT_W = 3;    // split point field width
   localparam int COST_W  = 52;   // cost accumulator width

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic             dim_we;      // store the incoming dimension
      logic [IDX_W-1:0] dim_addr;    // dimension store address (read or write)
      logic             cost_we;     // write cost table entry (i, j)
      logic             cost_wbest;  // 1: write best cost, 0: write zero
      logic [IDX_W-1:0] i;           // first matrix of subchain
      logic [IDX_W-1:0] j;           // last matrix of subchain
      logic [IDX_W-1:0] k;           // split under trial
      logic             issue;       // launch split k into the pipeline
      logic             load_di;     // capture d[i-1]
      logic             load_pij;    // capture d[i-1] * d[j]
      logic             init_best;   // best := max, split := 0
      logic             zero_best;   // best := 0, split := 0
      logic             emit;        // load the result register
      logic             too_many;    // dropped-dimension flag for this chain
      logic             last_res;    // final result of the table
   } mco_cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic pipe_busy;   // split products still in flight
      logic out_busy;    // result register holds a word not yet taken
   } mco_status_type;

endpackage

`default_nettype wire

FILE: rtl/mco_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mco_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/mco_dpath.sv
// ----------------------------------------------------------------------------
// Matrix chain order datapath
// Dimension store, duplicated cost table, split cost pipeline, best-split
// tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mco_dpath #(
   parameter int MAX_MATRICES = 8,
   parameter int DIM_BITS     = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [mco_pkg::DIM_W-1:0]    req_dimension,
   input  wire mco_pkg::mco_cmd_type         cmd,
   output mco_pkg::mco_status_type           status,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [mco_pkg::IDX_W-1:0]         rsp_first_matrix,
   output logic [mco_pkg::IDX_W-1:0]         rsp_last_matrix,
   output logic [mco_pkg::COST_W-1:0]        rsp_min_cost,
   output logic [mco_pkg::SPLIT_W-1:0]       rsp_split_point,
   output logic                              rsp_too_many,
   output logic                              rsp_end_of_table
);

   import mco_pkg::*;

   localparam int SLOTS = MAX_MATRICES + 1;
   localparam int IW    = $clog2(SLOTS);
   localparam int CA    = 2 * IW;
   localparam int CDEPTH = 2 ** CA;

   // memory ports
   logic [DIM_BITS-1:0] dim_rdata;
   logic [COST_W-1:0]   cost_a_rdata;
   logic [COST_W-1:0]   cost_b_rdata;
   logic [COST_W-1:0]   cost_wdata;
   logic [CA-1:0]       cost_waddr;
   logic [CA-1:0]       cost_a_addr;
   logic [CA-1:0]       cost_b_addr;
   logic [IDX_W-1:0]    k_next;

   // pipeline and tracking registers
   logic [DIM_BITS-1:0]   di_ff, di_in;
   logic [2*DIM_BITS-1:0] pij_ff, pij_in;
   logic                  v1_ff, v1_in;
   logic [IDX_W-1:0]      k1_ff, k1_in;
   logic                  v2_ff, v2_in;
   logic [IDX_W-1:0]      k2_ff, k2_in;
   logic [COST_W-1:0]     sum_ff, sum_in;
   logic [COST_W-1:0]     prod_ff, prod_in;
   logic [COST_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]      split_ff, split_in;
   logic [3*DIM_BITS-1:0] prod_full;
   logic [COST_W-1:0]     cand;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]      out_first_ff, out_first_in;
   logic [IDX_W-1:0]      out_last_ff, out_last_in;
   logic [COST_W-1:0]     out_cost_ff, out_cost_in;
   logic [SPLIT_W-1:0]    out_split_ff, out_split_in;
   logic                  out_many_ff, out_many_in;
   logic                  out_end_ff, out_end_in;

   // addresses: cost entry (i, j) sits at {i, j}
   assign k_next      = cmd.k + IDX_W'(1);
   assign cost_waddr  = {cmd.i[IW-1:0], cmd.j[IW-1:0]};
   assign cost_a_addr = {cmd.i[IW-1:0], cmd.k[IW-1:0]};
   assign cost_b_addr = {k_next[IW-1:0], cmd.j[IW-1:0]};
   assign cost_wdata  = cmd.cost_wbest ? best_ff : '0;

   mco_ram #(
      .WIDTH (DIM_BITS),
      .DEPTH (SLOTS)
   ) u_dim_ram (
      .clock   (clock),
      .wr_en   (cmd.dim_we),
      .wr_addr (cmd.dim_addr[IW-1:0]),
      .wr_data (req_dimension[DIM_BITS-1:0]),
      .rd_addr (cmd.dim_addr[IW-1:0]),
      .rd_data (dim_rdata)
   );

   // two copies of the cost table: left and right subchain reads per cycle
   mco_ram #(
      .WIDTH (COST_W),
      .DEPTH (CDEPTH)
   ) u_cost_a (
      .clock   (clock),
      .wr_en   (cmd.cost_we),
      .wr_addr (cost_waddr),
      .wr_data (cost_wdata),
      .rd_addr (cost_a_addr),
      .rd_data (cost_a_rdata)
   );

   mco_ram #(
      .WIDTH (COST_W),
      .DEPTH (CDEPTH)
   ) u_cost_b (
      .clock   (clock),
      .wr_en   (cmd.cost_we),
      .wr_addr (cost_waddr),
      .wr_data (cost_wdata),
      .rd_addr (cost_b_addr),
      .rd_data (cost_b_rdata)
   );

   // outer dimension product d[i-1] * d[j]
   always_comb begin
      di_in  = cmd.load_di  ? dim_rdata : di_ff;
      pij_in = cmd.load_pij ? (2*DIM_BITS)'(di_ff * dim_rdata) : pij_ff;
   end

   // split pipeline: read, multiply and add, compare
   assign prod_full = pij_ff * dim_rdata;
   assign cand      = sum_ff + prod_ff;

   always_comb begin
      v1_in   = cmd.issue;
      k1_in   = cmd.k;
      v2_in   = v1_ff;
      k2_in   = k1_ff;
      sum_in  = cost_a_rdata + cost_b_rdata;
      prod_in = COST_W'(prod_full);
   end

   // best cost so far; a later split wins only when strictly cheaper
   always_comb begin
      best_in  = best_ff;
      split_in = split_ff;
      priority if (cmd.init_best) begin
         best_in  = COST_MAX;
         split_in = '0;
      end else if (cmd.zero_best) begin
         best_in  = '0;
         split_in = '0;
      end else if (v2_ff && (cand < best_ff)) begin
         best_in  = cand;
         split_in = k2_ff;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_first_in = out_first_ff;
      out_last_in  = out_last_ff;
      out_cost_in  = out_cost_ff;
      out_split_in = out_split_ff;
      out_many_in  = out_many_ff;
      out_end_in   = out_end_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_first_in = cmd.i;
         out_last_in  = cmd.j;
         out_cost_in  = best_ff;
         out_split_in = SPLIT_W'(split_ff);
         out_many_in  = cmd.too_many;
         out_end_in   = cmd.last_res;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      di_ff        <= di_in;
      pij_ff       <= pij_in;
      k1_ff        <= k1_in;
      k2_ff        <= k2_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      best_ff      <= best_in;
      split_ff     <= split_in;
      out_first_ff <= out_first_in;
      out_last_ff  <= out_last_in;
      out_cost_ff  <= out_cost_in;
      out_split_ff <= out_split_in;
      out_many_ff  <= out_many_in;
      out_end_ff   <= out_end_in;
   end

   assign status.pipe_busy = v1_ff | v2_ff;
   assign status.out_busy  = out_valid_ff & ~rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_first_matrix = out_first_ff;
   assign rsp_last_matrix  = out_last_ff;
   assign rsp_min_cost     = out_cost_ff;
   assign rsp_split_point  = out_split_ff;
   assign rsp_too_many     = out_many_ff;
   assign rsp_end_of_table = out_end_ff;

endmodule

`default_nettype wire

FILE: rtl/mco_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix chain order controller
// Loads the chain, then walks subchain lengths, start points and splits.
// ----------------------------------------------------------------------------
`default_nettype none

module mco_ctrl #(
   parameter int MAX_MATRICES = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_last_dim,
   output logic                          req_ready,
   input  wire mco_pkg::mco_status_type  status,
   output mco_pkg::mco_cmd_type          cmd
);

   import mco_pkg::*;

   localparam int SLOTS = MAX_MATRICES + 1;
   localparam int IW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);

   localparam logic [2:0] ST_LOAD    = 3'd0;
   localparam logic [2:0] ST_FETCH_I = 3'd1;
   localparam logic [2:0] ST_FETCH_J = 3'd2;
   localparam logic [2:0] ST_PROD    = 3'd3;
   localparam logic [2:0] ST_RUN     = 3'd4;
   localparam logic [2:0] ST_DRAIN   = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [IW-1:0] len_ff, len_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] k_ff, k_in;

   logic [IW-1:0] j_idx;
   logic [CW-1:0] n_cnt;
   logic [CW-1:0] count_add;
   logic          has_room;
   logic          accept;
   logic          table_done;
   logic          row_done;

   assign j_idx      = IW'(i_ff + len_ff - IW'(1));
   assign n_cnt      = count_ff - CW'(1);
   assign has_room   = (count_ff < CW'(SLOTS));
   assign count_add  = count_ff + CW'(has_room);
   assign accept     = req_valid & req_ready;
   assign table_done = (CW'(len_ff) == n_cnt);
   assign row_done   = (CW'(j_idx) == n_cnt);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      req_ready    = (state_ff == ST_LOAD);
      cmd          = '0;
      cmd.i        = IDX_W'(i_ff);
      cmd.j        = IDX_W'(j_idx);
      cmd.k        = IDX_W'(k_ff);
      cmd.too_many = ovf_ff;
      cmd.last_res = table_done;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.dim_addr = IDX_W'(count_ff);
            if (accept) begin
               // store the word and zero the diagonal entry of the new matrix
               cmd.dim_we  = has_room;
               cmd.cost_we = has_room & (count_ff != '0);
               cmd.i       = IDX_W'(count_ff);
               cmd.j       = IDX_W'(count_ff);
               count_in    = count_add;
               ovf_in      = ovf_ff | ~has_room;
               if (req_last_dim) begin
                  if (count_add < CW'(2)) begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end else if (count_add == CW'(2)) begin
                     // single matrix: one zero-cost result
                     i_in          = IW'(1);
                     len_in        = IW'(1);
                     cmd.zero_best = 1'b1;
                     state_in      = ST_EMIT;
                  end else begin
                     i_in     = IW'(1);
                     len_in   = IW'(2);
                     state_in = ST_FETCH_I;
                  end
               end
            end
         end
         ST_FETCH_I: begin
            cmd.dim_addr = IDX_W'(i_ff - IW'(1));
            state_in     = ST_FETCH_J;
         end
         ST_FETCH_J: begin
            cmd.dim_addr = IDX_W'(j_idx);
            cmd.load_di  = 1'b1;
            state_in     = ST_PROD;
         end
         ST_PROD: begin
            cmd.load_pij  = 1'b1;
            cmd.init_best = 1'b1;
            k_in          = i_ff;
            state_in      = ST_RUN;
         end
         ST_RUN: begin
            // one split per cycle, lowest first
            cmd.dim_addr = IDX_W'(k_ff);
            cmd.issue    = 1'b1;
            k_in         = k_ff + IW'(1);
            if (k_ff == j_idx - IW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit       = 1'b1;
               cmd.cost_we    = 1'b1;
               cmd.cost_wbest = 1'b1;
               priority if (table_done) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else if (row_done) begin
                  len_in   = len_ff + IW'(1);
                  i_in     = IW'(1);
                  state_in = ST_FETCH_I;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_FETCH_I;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // loop indices
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      i_ff   <= i_in;
      k_ff   <= k_in;
   end

endmodule

`default_nettype wire

FILE: rtl/matrix_chain_order.sv
// The request side is ready only while loading. After the last word, each
// subchain pair (i, j) goes through dimension fetch, one split per cycle
// through the multiply/add pipeline, drain and write back; the write back
// waits while the result register holds a word not yet taken.
// Reset (synchronous, active high) clears the sequencer, counts and valid bits.
// ----------------------------------------------------------------------------
// Matrix chain order
// Minimum multiplication order of a matrix chain by dynamic programming.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_chain_order_defines.svh"

module matrix_chain_order #(
   parameter int MAX_MATRICES = 8,
   parameter int DIM_BITS     = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mco_pkg::DIM_W-1:0]     req_dimension,
   input  wire logic                          req_last_dim,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mco_pkg::IDX_W-1:0]          rsp_first_matrix,
   output logic [mco_pkg::IDX_W-1:0]          rsp_last_matrix,
   output logic [mco_pkg::COST_W-1:0]         rsp_min_cost,
   output logic [mco_pkg::SPLIT_W-1:0]        rsp_split_point,
   output logic                               rsp_too_many,
   output logic                               rsp_end_of_table
);

   import mco_pkg::*;

   mco_cmd_type    cmd;
   mco_status_type status;
   logic           pair_ordered;

   mco_ctrl #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_dim (req_last_dim),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd)
   );

   mco_dpath #(
      .MAX_MATRICES (MAX_MATRICES),
      .DIM_BITS     (DIM_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_dimension    (req_dimension),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_first_matrix (rsp_first_matrix),
      .rsp_last_matrix  (rsp_last_matrix),
      .rsp_min_cost     (rsp_min_cost),
      .rsp_split_point  (rsp_split_point),
      .rsp_too_many     (rsp_too_many),
      .rsp_end_of_table (rsp_end_of_table)
   );

   assign pair_ordered = (rsp_last_matrix >= rsp_first_matrix);

   // checks
   `MCO_ASSERT(a_emit_drained, clock, reset, cmd.emit |-> !status.pipe_busy, "emit while busy")
   `MCO_ASSERT(a_write_no_issue, clock, reset, cmd.cost_we |-> !cmd.issue, "write on issue")
   `MCO_ASSERT(a_pair_order, clock, reset, rsp_valid |-> pair_ordered, "j below i")
   `MCO_ASSERT_NEXT(a_end_reload, clock, reset, cmd.emit && cmd.last_res, req_ready, "no reload")

endmodule

`default_nettype wire

FILE: bench/tb_matrix_chain_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain order testbench
// Sends dimension chains over the request channel. A short scripted table
// comes first, then random chains. Each result word is checked against an
// in-bench dynamic-program model of the cost and split tables. Both sides
// idle at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_matrix_chain_order;
   import mco_pkg::*;

   localparam int MAX_MATRICES = 8;
   localparam int DIM_SLOTS    = MAX_MATRICES + 1;
   localparam int RANDOM_WORDS = 130;
   localparam int HOLD_CYCLES  = 400;    // long response stall
   localparam int DRAIN_CYCLES = 300;    // quiet watch for stray result words
   localparam int STALL_LIMIT  = 3000;   // cycles with no handshake at all

   // One result word
   typedef struct packed {
      logic [IDX_W-1:0]   first_idx;
      logic [IDX_W-1:0]   last_idx;
      logic [COST_W-1:0]  cost;
      logic [SPLIT_W-1:0] split;
      logic               too_many;
      logic               end_tab;
   } chain_result_type;

   // One scripted request word, with an optional typed-in result
   typedef struct packed {
      logic [DIM_W-1:0] dim;
      logic             last;
      logic             typed;
      chain_result_type want;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [DIM_W-1:0]    req_dimension = '0;
   logic                req_last_dim = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [IDX_W-1:0]    rsp_first_matrix;
   logic [IDX_W-1:0]    rsp_last_matrix;
   logic [COST_W-1:0]   rsp_min_cost;
   logic [SPLIT_W-1:0]  rsp_split_point;
   logic                rsp_too_many;
   logic                rsp_end_of_table;

   // Typed-in result that travels with the word on offer
   logic                cur_typed = 1'b0;
   chain_result_type    cur_want = '0;

   // Model state: dimensions held for the open chain
   logic [DIM_W-1:0]    chain_dims [0:DIM_SLOTS-1];
   int                  chain_len = 0;
   logic                chain_dropped = 1'b0;

   chain_result_type    due_costs [$];
   chain_result_type    head;
   script_row_type      script [$];
   int                  error_count = 0;
   int                  quiet_cycles = 0;
   int                  before_count;
   int unsigned         send_idle_pct = 8;
   int unsigned         recv_idle_pct = 72;
   logic                hold_request = 1'b0;
   logic                hold_done = 1'b0;

   matrix_chain_order u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_dimension    (req_dimension),
      .req_last_dim     (req_last_dim),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_first_matrix (rsp_first_matrix),
      .rsp_last_matrix  (rsp_last_matrix),
      .rsp_min_cost     (rsp_min_cost),
      .rsp_split_point  (rsp_split_point),
      .rsp_too_many     (rsp_too_many),
      .rsp_end_of_table (rsp_end_of_table)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Take one dimension word; on a closing word, queue the whole table
   function automatic void plan_chain(input logic [DIM_W-1:0] dim_in, input logic last_in);
      logic [COST_W-1:0]  best [1:MAX_MATRICES][1:MAX_MATRICES];
      logic [SPLIT_W-1:0] cut [1:MAX_MATRICES][1:MAX_MATRICES];
      logic [COST_W-1:0]  trial;
      chain_result_type   r;
      int                 n, j;

      if (chain_len < DIM_SLOTS) begin
         chain_dims[chain_len] = dim_in;
         chain_len++;
      end else begin
         chain_dropped = 1'b1;
      end
      if (!last_in)
         return;

      // Fewer than two dimensions: no matrix, nothing to report
      if (chain_len < 2) begin
         chain_len = 0;
         chain_dropped = 1'b0;
         return;
      end
      n = chain_len - 1;
      for (int i = 1; i <= n; i++) begin
         best[i][i] = '0;
         cut[i][i]  = '0;
      end

      if (n == 1) begin
         r = '{first_idx: 4'd1, last_idx: 4'd1, cost: '0, split: '0,
               too_many: chain_dropped, end_tab: 1'b1};
         due_costs.insert(due_costs.size(), r);
      end else begin
         for (int len = 2; len <= n; len++) begin
            for (int i = 1; i + len - 1 <= n; i++) begin
               j = i + len - 1;
               best[i][j] = COST_MAX;
               cut[i][j]  = '0;
               // lowest split wins ties
               for (int k = i; k < j; k++) begin
                  trial = best[i][k] + best[k+1][j]
                        + COST_W'(chain_dims[i-1]) * chain_dims[k] * chain_dims[j];
                  if (trial < best[i][j]) begin
                     best[i][j] = trial;
                     cut[i][j]  = SPLIT_W'(k);
                  end
               end
               r.first_idx = IDX_W'(i);
               r.last_idx  = IDX_W'(j);
               r.cost      = best[i][j];
               r.split     = cut[i][j];
               r.too_many  = chain_dropped;
               r.end_tab   = (len == n);
               due_costs.insert(due_costs.size(), r);
            end
         end
      end
      chain_len = 0;
      chain_dropped = 1'b0;
   endfunction

   task automatic check_field(input string name, input logic [COST_W-1:0] want,
                              input logic [COST_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Handshake monitor: predict on request words, check response words
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_valid && req_ready) begin
            quiet_cycles = 0;
            before_count = due_costs.size();
            plan_chain(req_dimension, req_last_dim);
            if (cur_typed) begin
               while (due_costs.size() > before_count)
                  void'(due_costs.pop_back());
               due_costs.insert(due_costs.size(), cur_want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            quiet_cycles = 0;
            if (due_costs.size() == 0) begin
               $display("%0t: result word with none expected, got i=%0d j=%0d cost=%0d",
                        $time, rsp_first_matrix, rsp_last_matrix, rsp_min_cost);
               error_count++;
            end else begin
               head = due_costs.pop_front();
               check_field("first_matrix", head.first_idx, rsp_first_matrix);
               check_field("last_matrix", head.last_idx, rsp_last_matrix);
               check_field("min_cost", head.cost, rsp_min_cost);
               check_field("split_point", head.split, rsp_split_point);
               check_field("too_many", head.too_many, rsp_too_many);
               check_field("end_of_table", head.end_tab, rsp_end_of_table);
            end
         end
         // watchdog
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_matrix_chain_order: errors");
            $finish;
         end
      end
   end

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic add_row(input logic [DIM_W-1:0] dim, input logic last);
      script_row_type row;
      row = '0;
      row.dim  = dim;
      row.last = last;
      script.insert(script.size(), row);
   endtask

   task automatic add_typed(input logic [DIM_W-1:0] dim, input logic last,
                            input int i, input int j, input logic [COST_W-1:0] cost,
                            input int split);
      script_row_type row;
      row = '0;
      row.dim            = dim;
      row.last           = last;
      row.typed          = 1'b1;
      row.want.first_idx = IDX_W'(i);
      row.want.last_idx  = IDX_W'(j);
      row.want.cost      = cost;
      row.want.split     = SPLIT_W'(split);
      row.want.end_tab   = 1'b1;
      script.insert(script.size(), row);
   endtask

   // Offer one word and hold it until taken; returns at the accepting edge
   task automatic send_word(input logic [DIM_W-1:0] dim, input logic last,
                            input logic typed, input chain_result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_dimension <= dim;
      req_last_dim  <= last;
      cur_typed     <= typed;
      cur_want      <= want;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   function automatic logic [DIM_W-1:0] pick_dim();
      int unsigned mode;
      mode = $urandom_range(0, 99);
      if (mode < 45)
         return DIM_W'($urandom_range(0, 24));
      else if (mode < 75)
         return DIM_W'($urandom());
      else if (mode < 85)
         return {DIM_W{1'b1}};
      else if (mode < 90)
         return '0;
      else
         return DIM_W'($urandom_range(1000, 5000));
   endfunction

   // Stimulus
   initial begin : stimulus
      int unsigned random_sent;
      int unsigned n_words;
      int unsigned kind;

      random_sent = 0;

      // lone dimension right after reset: no matrix, no result
      add_row(16'd7, 1'b1);
      // single matrix
      add_row(16'd3, 1'b0);
      add_typed(16'd5, 1'b1, 1, 1, '0, 0);
      // two matrices at full-scale dimensions
      add_row(16'hFFFF, 1'b0);
      add_row(16'hFFFF, 1'b0);
      add_typed(16'hFFFF, 1'b1, 1, 2, 52'hFFFD_0002_FFFF, 1);
      // all-zero dimensions: zero costs, first split kept
      add_row(16'd0, 1'b0);
      add_row(16'd0, 1'b0);
      add_row(16'd0, 1'b0);
      add_row(16'd0, 1'b1);
      // store full: the tenth word and the closing word are dropped
      add_row(16'd30, 1'b0);
      add_row(16'd35, 1'b0);
      add_row(16'd15, 1'b0);
      add_row(16'd5, 1'b0);
      add_row(16'd10, 1'b0);
      add_row(16'd20, 1'b0);
      add_row(16'd25, 1'b0);
      add_row(16'd12, 1'b0);
      add_row(16'd40, 1'b0);
      add_row(16'hFFFF, 1'b0);
      add_row(16'h0001, 1'b1);

      while (reset)
         @(posedge clock);

      foreach (script[r])
         send_word(script[r].dim, script[r].last, script[r].typed, script[r].want);

      // Random chains: mostly well formed, some empty, some overfull
      while (random_sent < RANDOM_WORDS) begin
         if (random_sent < RANDOM_WORDS / 3) begin
            send_idle_pct = 8;
            recv_idle_pct = 72;
         end else if (random_sent < 2 * RANDOM_WORDS / 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_request  = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 8)
            n_words = 1;
         else if (kind < 20)
            n_words = $urandom_range(DIM_SLOTS + 1, DIM_SLOTS + 3);
         else if (kind < 40)
            n_words = DIM_SLOTS;
         else
            n_words = $urandom_range(2, DIM_SLOTS - 1);
         for (int w = 0; w < n_words; w++)
            send_word(pick_dim(), (w == n_words - 1), 1'b0, '0);
         random_sent += n_words;
      end
      req_valid <= 1'b0;

      // wait for the tables to drain, then watch for stray words
      @(posedge clock);
      while (due_costs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb_matrix_chain_order: clean");
      else
         $display("tb_matrix_chain_order: errors");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/mco_pkg.sv
rtl/mco_ram.sv
rtl/mco_dpath.sv
rtl/mco_ctrl.sv
rtl/matrix_chain_order.sv
bench/tb_matrix_chain_order.sv
